FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files; tile_map_box_sweep_top includes them.
// Clock and reset are passed in; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: hdl/tmbs_pkg.sv
// Shared types and codes for the tile map box sweep block.
// No dependencies.
`timescale 1ns / 1ps
package tmbs_pkg;
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_WRITE  = 2'd0;
	localparam cmd_t CMD_SWEEP  = 2'd1;
	localparam cmd_t CMD_GROUND = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	typedef logic [6:0] cfg_data_t;
	localparam cfg_idx_t REG_MAP_COLS    = 2'd0;
	localparam cfg_idx_t REG_MAP_ROWS    = 2'd1;
	localparam cfg_idx_t REG_TILE_WIDTH  = 2'd2;
	localparam cfg_idx_t REG_TILE_HEIGHT = 2'd3;

	typedef logic signed [19:0] coord_t;
	typedef logic [15:0] size_t;
	typedef logic signed [15:0] move_t;
	typedef logic [5:0] tile_pos_t;
	typedef logic [15:0] tile_val_t;
	typedef logic signed [1:0] norm_t;

	// Request to the shared divider.
	typedef struct packed {
		logic start;
		logic floor_mode;
	} div_req_t;
endpackage

FILE: hdl/tmbs_ifs.sv
// Valid/ready channel interfaces for query items and result items.
// Depends on tmbs_pkg.
`timescale 1ns / 1ps
interface tmbs_in_if;
	import tmbs_pkg::*;
	logic      valid;
	logic      ready;
	cmd_t      cmd;
	tile_pos_t tile_col;
	tile_pos_t tile_row;
	tile_val_t tile_value;
	coord_t    box_x;
	coord_t    box_y;
	size_t     box_w;
	size_t     box_h;
	move_t     move_x;
	move_t     move_y;
	modport source (output valid, cmd, tile_col, tile_row, tile_value, box_x, box_y,
		box_w, box_h, move_x, move_y, input ready);
	modport sink (input valid, cmd, tile_col, tile_row, tile_value, box_x, box_y,
		box_w, box_h, move_x, move_y, output ready);
endinterface

interface tmbs_out_if;
	import tmbs_pkg::*;
	logic   valid;
	logic   ready;
	coord_t allowed_x;
	coord_t allowed_y;
	norm_t  normal_x;
	norm_t  normal_y;
	logic   collided;
	logic   grounded;
	modport source (output valid, allowed_x, allowed_y, normal_x, normal_y, collided,
		grounded, input ready);
	modport sink (input valid, allowed_x, allowed_y, normal_x, normal_y, collided,
		grounded, output ready);
endinterface

FILE: hdl/tmbs_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Gives truncated or floored quotient. Depends on tmbs_pkg.
`timescale 1ns / 1ps
module tmbs_div #(
	parameter int PW = 23,
	parameter int DW = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmbs_pkg::div_req_t    req,
	input  logic signed [PW-1:0]  dividend,
	input  logic [DW-1:0]         divisor,
	output logic                  done,
	output logic signed [PW-1:0]  quot
);
	import tmbs_pkg::*;
	localparam int CNW = $clog2(PW + 1);

	logic           busy_q, done_q, neg_q, floor_q;
	logic [CNW-1:0] cnt_q;
	logic [PW-1:0]  mag_q;
	logic [DW-1:0]  rem_q, d_q;
	logic [DW:0]    trial;
	logic           ge;
	logic [DW:0]    diff;

	assign trial = {rem_q, mag_q[PW-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the magnitude through the partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q   <= dividend[PW-1];
			floor_q <= req.floor_mode;
			mag_q   <= dividend[PW-1] ? PW'(-dividend) : PW'(dividend);
			rem_q   <= '0;
			d_q     <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			mag_q <= {mag_q[PW-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q)
			quot = -$signed(mag_q) - ((floor_q && rem_q != '0) ? PW'(1) : PW'(0));
		else
			quot = $signed(mag_q);
	end
	assign done = done_q;
endmodule

FILE: hdl/tile_map_box_sweep_top.sv
// Tile map box sweep: each sweep pass runs four divisions for the tile bounds (divider
// width PW = 23 at default settings) and then scans the covered tiles, if there are any;
// a sweep runs up to two passes, a grounded query one; the result is then registered and posted.
// One item at a time: the shared divider and the scan sequencer set the rate.
// Reset clears control state and restores the map registers (64x64, 16x16 px);
// tile memory contents are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tile_map_box_sweep_top #(
	parameter int MAX_COLS     = 64,
	parameter int MAX_ROWS     = 64,
	parameter int TILE_ID_BITS = 16,
	parameter int FRAC_BITS    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tmbs_in_if.sink              in_ch,
	tmbs_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  tmbs_pkg::cfg_idx_t   cfg_idx,
	input  tmbs_pkg::cfg_data_t  cfg_data
);
	import tmbs_pkg::*;

	// Widths: coordinates must hold box + size + move, and tile size * tile count.
	localparam int MAXD   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int PB     = 10 + FRAC_BITS + $clog2(MAXD + 1);
	localparam int PW     = (PB > 23) ? PB : 23;
	localparam int DW     = 7 + FRAC_BITS;
	localparam int XW     = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int AW     = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1;
	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int MARGIN = ((1 << FRAC_BITS) + 5) / 10;

	typedef logic signed [PW-1:0] pos_t;

	localparam pos_t ONE_PX  = pos_t'(1 << FRAC_BITS);
	localparam pos_t MARG    = pos_t'(MARGIN);
	localparam pos_t SAT_HI  = pos_t'(524287);
	localparam pos_t SAT_LO  = -pos_t'(524288);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_CHECK, S_SCAN, S_DRAIN, S_PASS, S_DONE
	} state_t;
	typedef enum logic [1:0] {P_X, P_Y, P_G} pass_t;

	state_t state_q;
	pass_t  mode_q;

	// Configuration registers.
	cfg_data_t map_cols_q, map_rows_q, tile_w_q, tile_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= 7'd64;
			map_rows_q <= 7'd64;
			tile_w_q   <= 7'd16;
			tile_h_q   <= 7'd16;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAP_COLS:    map_cols_q <= cfg_data;
				REG_MAP_ROWS:    map_rows_q <= cfg_data;
				REG_TILE_WIDTH:  tile_w_q   <= cfg_data;
				REG_TILE_HEIGHT: tile_h_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Effective map size, clamped to the maximum, and tile size in fixed point; zero tile size acts as one.
	logic [DW-1:0] tw_fx, th_fx;
	pos_t          tw_s, th_s, nc_s, nr_s;
	assign tw_fx = DW'((tile_w_q == '0) ? 7'd1 : tile_w_q) << FRAC_BITS;
	assign th_fx = DW'((tile_h_q == '0) ? 7'd1 : tile_h_q) << FRAC_BITS;
	assign tw_s  = $signed(PW'(tw_fx));
	assign th_s  = $signed(PW'(th_fx));
	assign nc_s  = (int'(map_cols_q) > MAX_COLS) ? pos_t'(MAX_COLS) : $signed(PW'(map_cols_q));
	assign nr_s  = (int'(map_rows_q) > MAX_ROWS) ? pos_t'(MAX_ROWS) : $signed(PW'(map_rows_q));

	// Item registers.
	pos_t bx_q, by_q, bw_q, bh_q, dx_q, dy_q;
	pos_t ol_q, oh_q, il_q, ih_q;
	pos_t ox_q, oy_q;
	norm_t nx_q, ny_q;
	logic [1:0] k_q;
	logic any_q, hit_q, g_q, start_q;
	logic [XW-1:0] o_q, i_q, ohi_q, ihi_q, ilo_q, hit_o_q;

	// Per-pass view: p is the swept axis, q the orthogonal one.
	pos_t p, ps, m, q, qs, sz_o, sz_i, n_o, n_i;
	logic mneg;
	always_comb begin
		if (mode_q == P_Y) begin
			p = by_q; ps = bh_q; m = dy_q; q = bx_q; qs = bw_q;
			sz_o = th_s; sz_i = tw_s; n_o = nr_s; n_i = nc_s;
		end else begin
			p = bx_q; ps = bw_q; m = dx_q; q = by_q; qs = bh_q;
			sz_o = tw_s; sz_i = th_s; n_o = nc_s; n_i = nr_s;
		end
		mneg = m[PW-1];
	end

	// Divider operand selection for the four bounds of a pass.
	div_req_t      div_req;
	pos_t          div_a, div_q;
	logic [DW-1:0] div_d;
	logic          div_done;
	logic          div_floor;
	always_comb begin
		div_a     = p;
		div_floor = 1'b0;
		unique case (k_q)
			2'd0: begin
				div_a     = (mode_q == P_G || mneg) ? p + ((mode_q == P_G) ? '0 : m) : p;
				div_floor = (mode_q == P_G) || mneg;
			end
			2'd1: begin
				div_a     = (mode_q != P_G && !mneg) ? p + ps + m : p + ps;
				div_floor = (mode_q == P_G);
			end
			2'd2: begin
				div_a     = (mode_q == P_G) ? q + qs + ONE_PX : q;
				div_floor = (mode_q == P_G);
			end
			default: begin
				div_a     = (mode_q == P_G) ? q + qs + ONE_PX : q + qs;
				div_floor = (mode_q == P_G);
			end
		endcase
		div_d = (k_q[1] == 1'b0) ? DW'(sz_o) : DW'(sz_i);
		div_req.start      = start_q;
		div_req.floor_mode = div_floor;
	end

	tmbs_div #(.PW(PW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_a),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_q)
	);

	// Clipped bounds.
	pos_t ol_c, oh_c, il_c, ih_c;
	logic empty, g_off;
	assign ol_c  = (ol_q < 0) ? '0 : ol_q;
	assign oh_c  = (oh_q > n_o - 1) ? n_o - 1 : oh_q;
	assign il_c  = (il_q < 0) ? '0 : il_q;
	assign ih_c  = (ih_q > n_i - 1) ? n_i - 1 : ih_q;
	assign empty = (ol_c > oh_c) || (il_c > ih_c);
	assign g_off = (il_q < 0) || (il_q >= nr_s) || (ol_q < 0) || (oh_q >= nc_s);

	// Tile memory, single write port and registered read.
	logic [TILE_ID_BITS-1:0] mem [DEPTH];
	logic [TILE_ID_BITS-1:0] rd_s1;
	logic [AW-1:0]           rd_addr, wr_addr;
	logic                    wr_en, pend_s1;
	logic [XW-1:0]           po_s1;
	logic [XW-1:0]           sc_c, sc_r;
	logic                    in_acc;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign sc_c    = (mode_q == P_Y) ? i_q : o_q;
	assign sc_r    = (mode_q == P_Y) ? o_q : i_q;
	assign rd_addr = AW'(sc_r) * AW'(MAX_COLS) + AW'(sc_c);
	assign wr_addr = AW'(in_ch.tile_row) * AW'(MAX_COLS) + AW'(in_ch.tile_col);
	assign wr_en   = in_acc && in_ch.cmd == CMD_WRITE
		&& int'(in_ch.tile_col) < MAX_COLS && int'(in_ch.tile_row) < MAX_ROWS;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= TILE_ID_BITS'(in_ch.tile_value);
		rd_s1 <= mem[rd_addr];
	end

	// Pass end: distance to the hit tile edge (the full move if no hit), one multiply.
	logic [XW:0] hit_idx;
	pos_t        prod, off;
	norm_t       nrm;
	assign hit_idx = {1'b0, hit_o_q} + (mneg ? (XW+1)'(1) : '0);
	assign prod    = sz_o * $signed(PW'(hit_idx));
	assign off     = !hit_q ? m : (mneg ? prod - p + MARG : prod - (p + ps) - MARG);
	assign nrm     = !hit_q ? 2'sd0 : (mneg ? 2'sd1 : -2'sd1);

	function automatic coord_t sat20(input pos_t v);
		pos_t t;
		t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return coord_t'(t);
	endfunction

	// Sequencer and result register.
	logic out_valid_q;
	logic out_free;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= P_X;
			start_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			any_q       <= 1'b0;
			g_q         <= 1'b0;
		end else begin
			start_q <= 1'b0;
			pend_s1 <= 1'b0;
			if (out_ch.ready)
				out_valid_q <= 1'b0;

			// Evaluate the tile read issued in the previous cycle.
			if (pend_s1 && rd_s1 != '0) begin
				if (mode_q == P_G) begin
					g_q <= 1'b1;
				end else begin
					if (mneg || !hit_q)
						hit_o_q <= po_s1;
					hit_q <= 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						bx_q  <= pos_t'(in_ch.box_x);
						by_q  <= pos_t'(in_ch.box_y);
						bw_q  <= $signed(PW'(in_ch.box_w));
						bh_q  <= $signed(PW'(in_ch.box_h));
						dx_q  <= pos_t'(in_ch.move_x);
						dy_q  <= pos_t'(in_ch.move_y);
						ox_q  <= pos_t'(in_ch.move_x);
						oy_q  <= pos_t'(in_ch.move_y);
						nx_q  <= 2'sd0;
						ny_q  <= 2'sd0;
						any_q <= 1'b0;
						hit_q <= 1'b0;
						g_q   <= 1'b0;
						k_q   <= '0;
						if (in_ch.cmd == CMD_SWEEP) begin
							if (in_ch.move_x != '0) begin
								mode_q  <= P_X;
								start_q <= 1'b1;
								state_q <= S_DIV;
							end else if (in_ch.move_y != '0) begin
								mode_q  <= P_Y;
								start_q <= 1'b1;
								state_q <= S_DIV;
							end else begin
								mode_q  <= P_X;
								state_q <= S_DONE;
							end
						end else if (in_ch.cmd == CMD_GROUND) begin
							mode_q  <= P_G;
							start_q <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						unique case (k_q)
							2'd0:    ol_q <= div_q;
							2'd1:    oh_q <= div_q;
							2'd2:    il_q <= div_q;
							default: ih_q <= div_q;
						endcase
						k_q <= k_q + 1'b1;
						if (k_q == 2'd3)
							state_q <= S_CHECK;
						else
							start_q <= 1'b1;
					end
				end
				S_CHECK: begin
					o_q   <= ol_c[XW-1:0];
					i_q   <= il_c[XW-1:0];
					ilo_q <= il_c[XW-1:0];
					ohi_q <= oh_c[XW-1:0];
					ihi_q <= ih_c[XW-1:0];
					if (mode_q == P_G) begin
						if (ol_q > oh_q) begin
							state_q <= S_DONE;
						end else if (g_off) begin
							g_q     <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						state_q <= empty ? S_PASS : S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= 1'b1;
					po_s1   <= o_q;
					if (i_q == ihi_q) begin
						i_q <= ilo_q;
						if (o_q == ohi_q)
							state_q <= S_DRAIN;
						else
							o_q <= o_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= (mode_q == P_G) ? S_DONE : S_PASS;
				end
				S_PASS: begin
					hit_q <= 1'b0;
					k_q   <= '0;
					if (mode_q == P_X) begin
						ox_q  <= off;
						nx_q  <= nrm;
						any_q <= hit_q;
						bx_q  <= bx_q + off;
						if (dy_q != '0) begin
							mode_q  <= P_Y;
							start_q <= 1'b1;
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						oy_q    <= off;
						ny_q    <= nrm;
						any_q   <= any_q || hit_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload, loaded as the transaction is posted.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (mode_q == P_G) begin
				out_ch.allowed_x <= '0;
				out_ch.allowed_y <= '0;
				out_ch.normal_x  <= 2'sd0;
				out_ch.normal_y  <= 2'sd0;
				out_ch.collided  <= 1'b0;
				out_ch.grounded  <= g_q;
			end else begin
				out_ch.allowed_x <= sat20(ox_q);
				out_ch.allowed_y <= sat20(oy_q);
				out_ch.normal_x  <= nx_q;
				out_ch.normal_y  <= ny_q;
				out_ch.collided  <= any_q;
				out_ch.grounded  <= 1'b0;
			end
		end
	end

	`ASSERT_IMPLIES(a_div_done_wait, clk, arst_n, div_done, state_q == S_DIV, "divider done early")
	`ASSERT_IMPLIES(a_scan_source, clk, arst_n, pend_s1, $past(state_q) == S_SCAN, "stray tile read")
	`ASSERT_NEXT(a_result_hold, clk, arst_n, state_q == S_DONE && out_valid_q && !out_ch.ready, state_q == S_DONE, "result overwritten")
endmodule
